[src/hble_pkg.sv]
// Package for the height bucket list engine.
// Holds widths, command codes, the controller state type and the control structs.
// No dependencies; every other source file imports it.
package hble_pkg;

    localparam int NODE_W      = 8;
    localparam int HEIGHT_W    = 9;
    localparam int FUNC_W      = 2;
    localparam int NUM_HEIGHTS = 512;
    localparam int NODE_SLOTS  = 256;
    localparam int LIMIT_W     = HEIGHT_W + 1;

    localparam logic [NODE_W-1:0]   NODE_COUNT_RESET = 8'd255;
    localparam logic [NODE_W-1:0]   NULL_LINK        = '0;
    localparam logic [HEIGHT_W-1:0] CLEAR_LAST       = HEIGHT_W'(NUM_HEIGHTS - 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INIT   = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_MOVE   = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UNLINK1,
        ST_UNLINK2,
        ST_LINK,
        ST_INIT,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_UNLINK1,
        OP_UNLINK2,
        OP_LINK,
        OP_INIT,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic  clr_last;
        func_t in_func;
        logic  in_ign;
        logic  is_move;
        logic  init_last;
        logic  out_free;
    } dp_status_t;

endpackage

[src/hble_if.sv]
// Handshake interfaces for the height bucket list engine: command, response, config.
// Each carries valid, ready and its payload. Depends on hble_pkg for widths.
interface hble_cmd_if import hble_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [NODE_W-1:0]   node_id;
    logic [HEIGHT_W-1:0] height_label;

    modport source (output valid, output func, output node_id, output height_label,
                    input ready);
    modport sink   (input valid, input func, input node_id, input height_label,
                    output ready);
endinterface

interface hble_rsp_if import hble_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] head_node;
    logic              list_empty;
    logic              ignored;

    modport source (output valid, output head_node, output list_empty, output ignored,
                    input ready);
    modport sink   (input valid, input head_node, input list_empty, input ignored,
                    output ready);
endinterface

interface hble_cfg_if import hble_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

[src/height_bucket_list_engine_top.sv]
// Top level of the height bucket list engine.
// Instantiates hble_ctrl and hble_datapath; depends on hble_pkg and the interfaces.
//
//   Channel   Role   Word contents
//   cmd       sink   func, node_id, height_label
//   rsp       source head_node, list_empty, ignored
//   cfg       sink   node_count
//
// After reset the head, link, label and placed memories are cleared; cmd.ready stays low then.
// Queries and ignored words go straight to the response; remove and move pass the unlink
// steps, move then links, and init steps through nodes; each memory has a single write port.
// A new word is taken in the cycle after the previous response is loaded into the output register.
// A stalled response holds only the last step until rsp.ready frees the register.
module height_bucket_list_engine_top
    import hble_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    hble_cmd_if.sink   cmd,
    hble_rsp_if.source rsp,
    hble_cfg_if.sink   cfg
);

    ctl_cmd_t   ctl;
    dp_status_t sts;

    assign cfg.ready = 1'b1;

    hble_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    hble_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .in_func        (cmd.func),
        .in_node_id     (cmd.node_id),
        .in_height      (cmd.height_label),
        .cfg_valid      (cfg.valid),
        .cfg_node_count (cfg.node_count),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_head_node  (rsp.head_node),
        .out_list_empty (rsp.list_empty),
        .out_ignored    (rsp.ignored)
    );

endmodule

[src/hble_ctrl.sv]
// Controller state machine of the height bucket list engine.
// Sequences the datapath through commands; depends on hble_pkg.
module hble_ctrl
    import hble_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  dp_status_t sts,
    output ctl_cmd_t   ctl
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.in_ign)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        unique case (sts.in_func)
                            FUNC_INIT:   state_next = ST_INIT;
                            FUNC_REMOVE: state_next = ST_UNLINK1;
                            FUNC_MOVE:   state_next = ST_UNLINK1;
                            FUNC_QUERY:  state_next = ST_RESP;
                            default:     state_next = ST_RESP;
                        endcase
                    end
                end
            end
            ST_UNLINK1: state_next = ST_UNLINK2;
            ST_UNLINK2: state_next = sts.is_move ? ST_LINK : ST_RESP;
            ST_LINK:    state_next = ST_RESP;
            ST_INIT:
            begin
                if (sts.init_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl.op = OP_NONE;
        unique case (state_reg)
            ST_CLEAR:   ctl.op = OP_CLEAR;
            ST_IDLE:    ctl.op = accept ? OP_LATCH : OP_NONE;
            ST_UNLINK1: ctl.op = OP_UNLINK1;
            ST_UNLINK2: ctl.op = OP_UNLINK2;
            ST_LINK:    ctl.op = OP_LINK;
            ST_INIT:    ctl.op = OP_INIT;
            ST_RESP:    ctl.op = OP_RESULT;
            default:    ctl.op = OP_NONE;
        endcase
    end

endmodule

[src/hble_datapath.sv]
// Datapath of the height bucket list engine: link, label, placed and head memories,
// command latch, config register and response register. Depends on hble_pkg.
module hble_datapath
    import hble_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            ctl,
    output dp_status_t          sts,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [NODE_W-1:0]   in_node_id,
    input  logic [HEIGHT_W-1:0] in_height,
    input  logic                cfg_valid,
    input  logic [NODE_W-1:0]   cfg_node_count,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [NODE_W-1:0]   out_head_node,
    output logic                out_list_empty,
    output logic                out_ignored
);

    logic [NODE_W-1:0]   bkt_mem    [NUM_HEIGHTS];
    logic [NODE_W-1:0]   prev_mem   [NODE_SLOTS];
    logic [NODE_W-1:0]   next_mem   [NODE_SLOTS];
    logic [HEIGHT_W-1:0] label_mem  [NODE_SLOTS];
    logic                placed_mem [NODE_SLOTS];

    logic [NODE_W-1:0]   node_count_reg;
    logic [HEIGHT_W-1:0] clr_cnt_reg;
    func_t               func_reg;
    logic [NODE_W-1:0]   id_reg;
    logic [HEIGHT_W-1:0] h_reg;
    logic                ign_reg;
    logic [NODE_W-1:0]   k_reg;

    logic [NODE_W-1:0]   bkt_rd_reg;
    logic [NODE_W-1:0]   rd_prev_reg;
    logic [NODE_W-1:0]   rd_next_reg;
    logic [HEIGHT_W-1:0] rd_label_reg;
    logic                rd_placed_reg;

    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_head_reg;
    logic                out_empty_reg;
    logic                out_ign_reg;

    logic                bkt_we;
    logic [HEIGHT_W-1:0] bkt_wa;
    logic [NODE_W-1:0]   bkt_wd;
    logic                bkt_re;
    logic [HEIGHT_W-1:0] bkt_ra;
    logic                prev_we;
    logic [NODE_W-1:0]   prev_wa;
    logic [NODE_W-1:0]   prev_wd;
    logic                next_we;
    logic [NODE_W-1:0]   next_wa;
    logic [NODE_W-1:0]   next_wd;
    logic                label_we;
    logic [NODE_W-1:0]   label_wa;
    logic [HEIGHT_W-1:0] label_wd;
    logic                placed_we;
    logic [NODE_W-1:0]   placed_wa;
    logic                placed_wd;
    logic                node_re;

    logic [LIMIT_W-1:0]  height_limit;
    logic                height_ok;
    logic                node_ok;
    logic                in_ign;
    logic                out_free;
    logic                load_result;
    logic                unlink_active;

    assign height_limit = LIMIT_W'({2'b00, node_count_reg} + 10'd1) << 1;
    assign height_ok    = ({1'b0, in_height} < height_limit);
    assign node_ok      = (in_node_id != NULL_LINK) && (in_node_id <= node_count_reg);

    always_comb
    begin
        unique case (func_t'(in_func))
            FUNC_INIT:   in_ign = (node_count_reg == '0) || !height_ok;
            FUNC_REMOVE: in_ign = !node_ok;
            FUNC_MOVE:   in_ign = !node_ok || !height_ok;
            FUNC_QUERY:  in_ign = !height_ok;
            default:     in_ign = 1'b1;
        endcase
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign load_result   = (ctl.op == OP_RESULT) && out_free;
    assign unlink_active = (func_reg == FUNC_MOVE) || rd_placed_reg;

    assign sts.clr_last  = (clr_cnt_reg == CLEAR_LAST);
    assign sts.in_func   = func_t'(in_func);
    assign sts.in_ign    = in_ign;
    assign sts.is_move   = (func_reg == FUNC_MOVE);
    assign sts.init_last = (k_reg == node_count_reg);
    assign sts.out_free  = out_free;

    always_comb
    begin
        bkt_we    = 1'b0;
        bkt_wa    = h_reg;
        bkt_wd    = NULL_LINK;
        bkt_re    = 1'b0;
        bkt_ra    = h_reg;
        prev_we   = 1'b0;
        prev_wa   = id_reg;
        prev_wd   = NULL_LINK;
        next_we   = 1'b0;
        next_wa   = id_reg;
        next_wd   = NULL_LINK;
        label_we  = 1'b0;
        label_wa  = id_reg;
        label_wd  = h_reg;
        placed_we = 1'b0;
        placed_wa = id_reg;
        placed_wd = 1'b0;
        node_re   = 1'b0;
        unique case (ctl.op)
            OP_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_wa    = clr_cnt_reg;
                prev_we   = 1'b1;
                prev_wa   = clr_cnt_reg[NODE_W-1:0];
                next_we   = 1'b1;
                next_wa   = clr_cnt_reg[NODE_W-1:0];
                label_we  = 1'b1;
                label_wa  = clr_cnt_reg[NODE_W-1:0];
                label_wd  = '0;
                placed_we = 1'b1;
                placed_wa = clr_cnt_reg[NODE_W-1:0];
            end
            OP_LATCH:
            begin
                bkt_re  = 1'b1;
                bkt_ra  = in_height;
                node_re = 1'b1;
            end
            OP_UNLINK1:
            begin
                if (rd_placed_reg)
                begin
                    if (rd_prev_reg == NULL_LINK)
                    begin
                        bkt_we = 1'b1;
                        bkt_wa = rd_label_reg;
                        bkt_wd = rd_next_reg;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = rd_prev_reg;
                        next_wd = rd_next_reg;
                    end
                    if (rd_next_reg != NULL_LINK)
                    begin
                        prev_we = 1'b1;
                        prev_wa = rd_next_reg;
                        prev_wd = rd_prev_reg;
                    end
                end
            end
            OP_UNLINK2:
            begin
                prev_we   = unlink_active;
                next_we   = unlink_active;
                placed_we = unlink_active;
                placed_wd = (func_reg == FUNC_MOVE);
                label_we  = (func_reg == FUNC_MOVE);
                bkt_re    = (func_reg == FUNC_MOVE);
            end
            OP_LINK:
            begin
                next_we = 1'b1;
                next_wd = bkt_rd_reg;
                bkt_we  = 1'b1;
                bkt_wd  = id_reg;
                if (bkt_rd_reg != NULL_LINK)
                begin
                    prev_we = 1'b1;
                    prev_wa = bkt_rd_reg;
                    prev_wd = id_reg;
                end
            end
            OP_INIT:
            begin
                bkt_we    = 1'b1;
                bkt_wd    = NODE_W'(1);
                prev_we   = 1'b1;
                prev_wa   = k_reg;
                prev_wd   = k_reg - NODE_W'(1);
                next_we   = 1'b1;
                next_wa   = k_reg;
                next_wd   = (k_reg == node_count_reg) ? NULL_LINK : k_reg + NODE_W'(1);
                label_we  = 1'b1;
                label_wa  = k_reg;
                placed_we = 1'b1;
                placed_wa = k_reg;
                placed_wd = 1'b1;
            end
            OP_NONE, OP_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        if (bkt_re)
        begin
            bkt_rd_reg <= bkt_mem[bkt_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (node_re)
        begin
            rd_prev_reg <= prev_mem[in_node_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (node_re)
        begin
            rd_next_reg <= next_mem[in_node_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (label_we)
        begin
            label_mem[label_wa] <= label_wd;
        end
        if (node_re)
        begin
            rd_label_reg <= label_mem[in_node_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (placed_we)
        begin
            placed_mem[placed_wa] <= placed_wd;
        end
        if (node_re)
        begin
            rd_placed_reg <= placed_mem[in_node_id];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_node_count;
            end
            if (ctl.op == OP_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + HEIGHT_W'(1);
            end
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LATCH)
        begin
            func_reg <= func_t'(in_func);
            id_reg   <= in_node_id;
            h_reg    <= in_height;
            ign_reg  <= in_ign;
            k_reg    <= NODE_W'(1);
        end
        else if (ctl.op == OP_INIT)
        begin
            k_reg <= k_reg + NODE_W'(1);
        end
        if (load_result)
        begin
            out_ign_reg <= ign_reg;
            if (func_reg == FUNC_QUERY)
            begin
                out_head_reg  <= ign_reg ? NULL_LINK : bkt_rd_reg;
                out_empty_reg <= ign_reg || (bkt_rd_reg == NULL_LINK);
            end
            else
            begin
                out_head_reg  <= NULL_LINK;
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_head_node  = out_head_reg;
    assign out_list_empty = out_empty_reg;
    assign out_ignored    = out_ign_reg;

endmodule

[src/hble_checker.sv]
// Port-level checker for the height bucket list engine, bound to the top level.
// Depends on hble_pkg for widths.
module hble_checker
    import hble_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [NODE_W-1:0] rsp_head_node,
    input logic              rsp_list_empty,
    input logic              rsp_ignored
);

    // A word in progress blocks the next one: cmd_ready is low in the cycle after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command accepted in back-to-back cycles");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_head_node)
            && $stable(rsp_list_empty) && $stable(rsp_ignored)))
        else $error("stalled response changed");

    a_empty_null: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_list_empty) |-> (rsp_head_node == NULL_LINK))
        else $error("empty list reported with a head node");

    a_ignored_null: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ignored) |-> (rsp_head_node == NULL_LINK))
        else $error("ignored word reported a head node");

endmodule

bind height_bucket_list_engine_top hble_checker u_hble_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_head_node  (rsp.head_node),
    .rsp_list_empty (rsp.list_empty),
    .rsp_ignored    (rsp.ignored)
);

[tb/height_bucket_list_engine_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for height_bucket_list_engine_top: drives commands, predicts every response
// word from its own copy of the height lists and checks them in order.
// Depends on hble_pkg and the handshake interfaces in hble_if.
module height_bucket_list_engine_top_tb;
    import hble_pkg::*;

    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [NODE_W-1:0] head_node;
        logic              list_empty;
        logic              ignored;
    } answer_t;

    logic clk;
    logic rst_n;

    hble_cmd_if cmd_if ();
    hble_rsp_if rsp_if ();
    hble_cfg_if cfg_if ();

    height_bucket_list_engine_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    logic [NODE_W-1:0]   bucket_heads [NUM_HEIGHTS] = '{default: '0};
    logic [NODE_W-1:0]   prev_links   [NODE_SLOTS]  = '{default: '0};
    logic [NODE_W-1:0]   next_links   [NODE_SLOTS]  = '{default: '0};
    logic [HEIGHT_W-1:0] node_heights [NODE_SLOTS]  = '{default: '0};
    logic                node_in_list [NODE_SLOTS]  = '{default: '0};
    logic [NODE_W-1:0]   node_limit                 = NODE_COUNT_RESET;

    answer_t answers_due [$];
    int      mismatches      = 0;
    int      hold_off_cycles = 0;
    bit      send_idle       = 1'b1;
    bit      recv_idle       = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int height_limit();
        int lim;
        lim = 2 * (int'(node_limit) + 1);
        if (lim > NUM_HEIGHTS)
            lim = NUM_HEIGHTS;
        return lim;
    endfunction

    function automatic void unlink_node(int idx);
        logic [NODE_W-1:0] p;
        logic [NODE_W-1:0] q;
        if (!node_in_list[idx])
            return;
        p = prev_links[idx];
        q = next_links[idx];
        if (p == NULL_LINK)
            bucket_heads[node_heights[idx]] = q;
        else
            next_links[p] = q;
        if (q != NULL_LINK)
            prev_links[q] = p;
        prev_links[idx]   = NULL_LINK;
        next_links[idx]   = NULL_LINK;
        node_in_list[idx] = 1'b0;
    endfunction

    function automatic answer_t apply_list_command(func_t f, logic [NODE_W-1:0] id,
                                                   logic [HEIGHT_W-1:0] h);
        answer_t ans;
        int      n;
        bit      id_ok;
        bit      h_ok;
        ans   = '0;
        n     = int'(node_limit);
        id_ok = (id >= 1) && (int'(id) <= n);
        h_ok  = int'(h) < height_limit();
        case (f)
            FUNC_INIT:
            begin
                if (n == 0 || !h_ok)
                    ans.ignored = 1'b1;
                else
                begin
                    for (int k = 1; k <= n; k++)
                    begin
                        node_heights[k] = h;
                        node_in_list[k] = 1'b1;
                        prev_links[k]   = NODE_W'(k - 1);
                        next_links[k]   = (k == n) ? NULL_LINK : NODE_W'(k + 1);
                    end
                    bucket_heads[h] = NODE_W'(1);
                end
            end
            FUNC_REMOVE:
            begin
                if (!id_ok)
                    ans.ignored = 1'b1;
                else
                    unlink_node(int'(id));
            end
            FUNC_MOVE:
            begin
                if (!id_ok || !h_ok)
                    ans.ignored = 1'b1;
                else
                begin
                    unlink_node(int'(id));
                    node_heights[id] = h;
                    node_in_list[id] = 1'b1;
                    prev_links[id]   = NULL_LINK;
                    next_links[id]   = bucket_heads[h];
                    if (bucket_heads[h] != NULL_LINK)
                        prev_links[bucket_heads[h]] = id;
                    bucket_heads[h] = id;
                end
            end
            default:
            begin
                if (!h_ok)
                begin
                    ans.ignored    = 1'b1;
                    ans.list_empty = 1'b1;
                end
                else
                begin
                    ans.head_node  = bucket_heads[h];
                    ans.list_empty = (bucket_heads[h] == NULL_LINK);
                end
            end
        endcase
        return ans;
    endfunction

    task automatic send_word(func_t f, logic [NODE_W-1:0] id, logic [HEIGHT_W-1:0] h);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.func         <= f;
        cmd_if.node_id      <= id;
        cmd_if.height_label <= h;
        do @(posedge clk); while (!cmd_if.ready);
        answers_due.push_back(apply_list_command(f, id, h));
    endtask

    task automatic drain_answers();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (answers_due.size() != 0);
    endtask

    task automatic write_node_count(logic [NODE_W-1:0] count);
        drain_answers();
        cfg_if.valid      <= 1'b1;
        cfg_if.node_count <= count;
        do @(posedge clk); while (!cfg_if.ready);
        node_limit = count;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_word(FUNC_QUERY, 8'd0, 9'd0);
        send_word(FUNC_QUERY, 8'd0, 9'd511);
        send_word(FUNC_REMOVE, 8'd7, 9'd0);
        send_word(FUNC_MOVE, 8'd255, 9'd511);
        send_word(FUNC_MOVE, 8'd0, 9'd1);
        send_word(FUNC_INIT, 8'd0, 9'd511);
        send_word(FUNC_QUERY, 8'd0, 9'd511);
    endtask

    task automatic test_small_lists();
        write_node_count(8'd4);
        send_word(FUNC_INIT, 8'd0, 9'd9);
        send_word(FUNC_INIT, 8'd0, 9'd10);
        send_word(FUNC_QUERY, 8'd0, 9'd9);
        send_word(FUNC_MOVE, 8'd2, 9'd3);
        send_word(FUNC_REMOVE, 8'd1, 9'd0);
        send_word(FUNC_REMOVE, 8'd4, 9'd0);
        send_word(FUNC_QUERY, 8'd0, 9'd9);
        send_word(FUNC_MOVE, 8'd3, 9'd9);
        send_word(FUNC_MOVE, 8'd5, 9'd0);
        send_word(FUNC_QUERY, 8'd0, 9'd10);
        send_word(FUNC_INIT, 8'd0, 9'd0);
        send_word(FUNC_QUERY, 8'd0, 9'd3);
    endtask

    task automatic test_zero_count();
        write_node_count(8'd0);
        send_word(FUNC_INIT, 8'd0, 9'd0);
        send_word(FUNC_MOVE, 8'd1, 9'd0);
        send_word(FUNC_REMOVE, 8'd1, 9'd0);
        send_word(FUNC_QUERY, 8'd0, 9'd0);
    endtask

    task automatic test_lowered_count();
        write_node_count(8'd8);
        send_word(FUNC_INIT, 8'd0, 9'd5);
        write_node_count(8'd3);
        send_word(FUNC_REMOVE, 8'd3, 9'd0);
        send_word(FUNC_MOVE, 8'd4, 9'd1);
        send_word(FUNC_QUERY, 8'd0, 9'd5);
    endtask

    task automatic send_random_word();
        int                  n;
        int                  r;
        func_t               f;
        logic [NODE_W-1:0]   id;
        logic [HEIGHT_W-1:0] h;
        n = int'(node_limit);
        r = $urandom_range(0, 99);
        if (r < 4)
            f = FUNC_INIT;
        else if (r < 24)
            f = FUNC_REMOVE;
        else if (r < 62)
            f = FUNC_MOVE;
        else
            f = FUNC_QUERY;
        if (n > 0 && $urandom_range(0, 9) != 0)
            id = NODE_W'($urandom_range(1, n));
        else
            id = NODE_W'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r == 0)
            h = HEIGHT_W'($urandom_range(0, 511));
        else if (n > 0 && r < 5)
            h = node_heights[$urandom_range(1, n)];
        else
            h = HEIGHT_W'($urandom_range(0, height_limit() - 1));
        send_word(f, id, h);
    endtask

    task automatic test_random_lists(logic [NODE_W-1:0] count, int items);
        write_node_count(count);
        send_word(FUNC_INIT, 8'd0, HEIGHT_W'($urandom_range(0, height_limit() - 1)));
        for (int i = 0; i < items; i++)
        begin
            send_idle = (i % 96) < 64;
            recv_idle = ((i + 40) % 96) < 64;
            send_random_word();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        send_idle       = 1'b0;
        hold_off_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_random_word();
        send_idle = 1'b1;
    endtask

    initial
    begin
        int stall;
        answer_t want;
        answer_t got;
        @(posedge rst_n);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 4) : 0;
            if (hold_off_cycles > 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            got = '{rsp_if.head_node, rsp_if.list_empty, rsp_if.ignored};
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d", $time,
                         got.head_node, got.list_empty, got.ignored);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (got.head_node != want.head_node)
                    $display("%0t: head_node expected %0d actual %0d", $time,
                             want.head_node, got.head_node);
                if (got.list_empty != want.list_empty)
                    $display("%0t: list_empty expected %0d actual %0d", $time,
                             want.list_empty, got.list_empty);
                if (got.ignored != want.ignored)
                    $display("%0t: ignored expected %0d actual %0d", $time,
                             want.ignored, got.ignored);
                if (got != want)
                    mismatches++;
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.func         <= FUNC_INIT;
        cmd_if.node_id      <= '0;
        cmd_if.height_label <= '0;
        rsp_if.ready        <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.node_count   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_small_lists();
        test_zero_count();
        test_lowered_count();
        test_random_lists(8'd255, 250);
        test_random_lists(8'd3, 250);
        test_random_lists(8'd12, 250);
        test_random_lists(8'd1, 200);
        test_random_lists(8'd40, 250);
        test_backpressure();
        test_random_lists(8'd127, 250);
        test_random_lists(8'd255, 300);

        drain_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (answers_due.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, answers_due.size());
        if (mismatches == 0 && answers_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
